>>> hdl/att_pkg.sv
// Shared types and constants for the assembly text tokenizer.
`default_nettype none

package att_pkg;

  localparam int unsigned POS_BITS      = 16;
  localparam int unsigned LEN_BITS      = 8;
  localparam int unsigned MAX_TOKEN_LEN = 255;
  localparam int unsigned NUM_BITS      = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);

  typedef enum logic [3:0] {
    K_EOF      = 4'd0,
    K_NEWLINE  = 4'd1,
    K_IDENT    = 4'd2,
    K_NUMBER   = 4'd3,
    K_STRING   = 4'd4,
    K_REGISTER = 4'd5,
    K_COMMA    = 4'd6,
    K_COLON    = 4'd7,
    K_HASH     = 4'd8,
    K_LBRACKET = 4'd9,
    K_RBRACKET = 4'd10,
    K_UNKNOWN  = 4'd11
  } token_kind_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // First member sits in the highest bits, so kind lands at bit 0.
  typedef struct packed {
    logic [3:0]          register_index;
    logic [NUM_BITS-1:0] number_value;
    logic [LEN_BITS-1:0] token_length;
    logic [15:0]         start_column;
    logic [15:0]         start_line;
    token_kind_t         token_kind;
  } tok_rec_t;

  // Results of one byte: rec0 always first, rec1 only when two tokens close together.
  typedef struct packed {
    logic     v1;
    tok_rec_t rec0;
    tok_rec_t rec1;
  } tok_pair_t;

endpackage

`default_nettype wire

>>> hdl/assembly_text_tokenizer.sv
// Each token record is queued as its closing byte is taken; m_ sends them in order.
// Throughput: one text byte per cycle while the queue has room; a byte that closes two
// tokens needs two output beats. The four-entry token queue between scanner and output
// lets either side stall on its own. Reset (rst, synchronous, active high) returns the
// scanner to line 1, column 1, idle, and empties the token queue.
`default_nettype none

module assembly_text_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [3:0] token_kind, [19:4] start_line,
                                      // [35:20] start_column, [43:36] token_length,
                                      // [75:44] number_value, [79:76] register_index
  output logic             m_tlast
);

  logic               q_ready;
  logic               push;
  att_pkg::tok_pair_t push_pair;
  att_pkg::tok_rec_t  out_rec;

  assign s_tready = q_ready;
  assign m_tdata  = out_rec;

  att_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_char   (s_tdata),
    .q_ready   (q_ready),
    .push      (push),
    .push_pair (push_pair)
  );

  att_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pair (push_pair),
    .q_ready   (q_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

>>> hdl/att_front.sv
// Scanner front end: classifies each byte, tracks position and emits token pairs.
`default_nettype none

module att_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_char,
  input  wire logic               q_ready,
  output logic                    push,
  output att_pkg::tok_pair_t      push_pair
);

  typedef enum logic [4:0] {
    M_IDLE    = 5'b00001,
    M_NUM     = 5'b00010,
    M_IDENT   = 5'b00100,
    M_STR     = 5'b01000,
    M_COMMENT = 5'b10000
  } scan_mode_t;

  scan_mode_t                         mode, mode_next;
  logic [att_pkg::POS_BITS-1:0]       line, line_next;
  logic [att_pkg::POS_BITS-1:0]       col, col_next;
  logic [att_pkg::POS_BITS-1:0]       tok_line, tok_line_next;
  logic [att_pkg::POS_BITS-1:0]       tok_col, tok_col_next;
  logic [att_pkg::LEN_BITS-1:0]       cnt, cnt_next;
  logic [att_pkg::NUM_BITS-1:0]       acc, acc_next;
  logic [4:0]                         rmatch, rmatch_next;

  logic                               e1v, e2v, do_idle, accept;
  att_pkg::tok_rec_t                  e1, e2;
  logic                               is_dig, is_alpha, cnt_room;
  logic [3:0]                         digit;
  logic [att_pkg::NUM_BITS+3:0]       acc_mul;
  logic [att_pkg::POS_BITS-1:0]       col_inc, line_inc;

  function automatic att_pkg::tok_rec_t mk_rec(
    input att_pkg::token_kind_t            kind,
    input logic [att_pkg::POS_BITS-1:0]    l,
    input logic [att_pkg::POS_BITS-1:0]    cl,
    input logic [att_pkg::LEN_BITS-1:0]    len,
    input logic [att_pkg::NUM_BITS-1:0]    num,
    input logic [3:0]                      ridx
  );
    att_pkg::tok_rec_t r;
    r.token_kind     = kind;
    r.start_line     = l[15:0];
    r.start_column   = cl[15:0];
    r.token_length   = len;
    r.number_value   = num;
    r.register_index = ridx;
    return r;
  endfunction

  // Register candidate tracking for identifier bytes after the first.
  function automatic logic [4:0] ident_match(
    input logic [att_pkg::LEN_BITS-1:0] n,
    input logic [4:0]                   rm,
    input logic [7:0]                   c
  );
    logic       cand;
    logic [3:0] num;
    cand = 1'b0;
    num  = 4'd0;
    if (n == att_pkg::LEN_BITS'(1)) begin
      cand = rm[4] && (c >= att_pkg::CH_ZERO) && (c <= att_pkg::CH_NINE);
      num  = cand ? 4'(c - att_pkg::CH_ZERO) : 4'd0;
    end else if (n == att_pkg::LEN_BITS'(2)) begin
      cand = rm[4] && (rm[3:0] == 4'd1) && (c >= att_pkg::CH_ZERO) &&
             (c <= att_pkg::CH_FIVE);
      num  = cand ? 4'(4'd10 + 4'(c - att_pkg::CH_ZERO)) : 4'd0;
    end
    return {cand, num};
  endfunction

  assign accept   = in_valid && q_ready;
  assign is_dig   = (in_char >= att_pkg::CH_ZERO) && (in_char <= att_pkg::CH_NINE);
  assign is_alpha = ((in_char >= att_pkg::CH_UPPER_A) && (in_char <= att_pkg::CH_UPPER_Z)) ||
                    ((in_char >= att_pkg::CH_LOWER_A) && (in_char <= att_pkg::CH_LOWER_Z)) ||
                    (in_char == att_pkg::CH_UNDER);
  assign digit    = 4'(in_char - att_pkg::CH_ZERO);
  assign cnt_room = cnt < att_pkg::LEN_MAX;
  assign col_inc  = (col == att_pkg::POS_MAX) ? col : col + att_pkg::POS_ONE;
  assign line_inc = (line == att_pkg::POS_MAX) ? line : line + att_pkg::POS_ONE;
  assign acc_mul  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) +
                    (att_pkg::NUM_BITS + 4)'(digit);

  always_comb begin
    mode_next     = mode;
    line_next     = line;
    col_next      = col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    cnt_next      = cnt;
    acc_next      = acc;
    rmatch_next   = rmatch;
    e1v           = 1'b0;
    e2v           = 1'b0;
    e1            = '0;
    e2            = '0;
    do_idle       = 1'b0;

    case (mode)
      M_COMMENT: begin
        if (in_char != att_pkg::CH_NUL && in_char != att_pkg::CH_LF) begin
          col_next = col_inc;
        end else begin
          do_idle = 1'b1;
        end
      end
      M_NUM: begin
        if (is_dig && cnt_room) begin
          acc_next = (acc_mul[att_pkg::NUM_BITS+3:att_pkg::NUM_BITS] != 4'd0) ?
                     {att_pkg::NUM_BITS{1'b1}} : acc_mul[att_pkg::NUM_BITS-1:0];
          cnt_next = cnt + att_pkg::LEN_BITS'(1);
          col_next = col_inc;
        end else begin
          e1v     = 1'b1;
          e1      = mk_rec(att_pkg::K_NUMBER, tok_line, tok_col, cnt, acc, 4'd0);
          do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if ((is_alpha || is_dig) && cnt_room) begin
          rmatch_next = ident_match(cnt, rmatch, in_char);
          cnt_next    = cnt + att_pkg::LEN_BITS'(1);
          col_next    = col_inc;
        end else begin
          e1v = 1'b1;
          if (rmatch[4] && cnt >= att_pkg::LEN_BITS'(2)) begin
            e1 = mk_rec(att_pkg::K_REGISTER, tok_line, tok_col, cnt, '0, rmatch[3:0]);
          end else begin
            e1 = mk_rec(att_pkg::K_IDENT, tok_line, tok_col, cnt, '0, 4'd0);
          end
          do_idle = 1'b1;
        end
      end
      M_STR: begin
        if (in_char == att_pkg::CH_QUOTE) begin
          e1v       = 1'b1;
          e1        = mk_rec(att_pkg::K_STRING, tok_line, tok_col, cnt, '0, 4'd0);
          col_next  = col_inc;
          mode_next = M_IDLE;
        end else if (in_char != att_pkg::CH_NUL && cnt_room) begin
          cnt_next = cnt + att_pkg::LEN_BITS'(1);
          col_next = col_inc;
        end else begin
          e1v     = 1'b1;
          e1      = mk_rec(att_pkg::K_UNKNOWN, tok_line, tok_col, cnt, '0, 4'd0);
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      mode_next = M_IDLE;
      if (in_char == att_pkg::CH_NUL) begin
        e2v           = 1'b1;
        e2            = mk_rec(att_pkg::K_EOF, line, col, '0, '0, 4'd0);
        line_next     = att_pkg::POS_ONE;
        col_next      = att_pkg::POS_ONE;
        tok_line_next = att_pkg::POS_ONE;
        tok_col_next  = att_pkg::POS_ONE;
        cnt_next      = '0;
        acc_next      = '0;
        rmatch_next   = '0;
      end else if (in_char == att_pkg::CH_SPACE || in_char == att_pkg::CH_TAB ||
                   in_char == att_pkg::CH_CR) begin
        col_next = col_inc;
      end else if (in_char == att_pkg::CH_SEMI) begin
        mode_next = M_COMMENT;
        col_next  = col_inc;
      end else if (in_char == att_pkg::CH_LF) begin
        e2v       = 1'b1;
        e2        = mk_rec(att_pkg::K_NEWLINE, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
        line_next = line_inc;
        col_next  = att_pkg::POS_ONE;
      end else if (in_char == att_pkg::CH_QUOTE || is_dig || is_alpha) begin
        // Open a token at the current position
        tok_line_next = line;
        tok_col_next  = col;
        col_next      = col_inc;
        acc_next      = '0;
        rmatch_next   = '0;
        if (in_char == att_pkg::CH_QUOTE) begin
          mode_next = M_STR;
          cnt_next  = '0;
        end else if (is_dig) begin
          mode_next = M_NUM;
          cnt_next  = att_pkg::LEN_BITS'(1);
          acc_next  = att_pkg::NUM_BITS'(digit);
        end else begin
          mode_next   = M_IDENT;
          cnt_next    = att_pkg::LEN_BITS'(1);
          rmatch_next = {in_char == att_pkg::CH_UPPER_R, 4'd0};
        end
      end else begin
        e2v      = 1'b1;
        col_next = col_inc;
        case (in_char)
          att_pkg::CH_COMMA:
            e2 = mk_rec(att_pkg::K_COMMA, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
          att_pkg::CH_COLON:
            e2 = mk_rec(att_pkg::K_COLON, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
          att_pkg::CH_HASH:
            e2 = mk_rec(att_pkg::K_HASH, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
          att_pkg::CH_LBRACK:
            e2 = mk_rec(att_pkg::K_LBRACKET, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
          att_pkg::CH_RBRACK:
            e2 = mk_rec(att_pkg::K_RBRACKET, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
          default:
            e2 = mk_rec(att_pkg::K_UNKNOWN, line, col, att_pkg::LEN_BITS'(1), '0, 4'd0);
        endcase
      end
    end
  end

  // Pack so the first token always sits in rec0
  assign push           = accept && (e1v || e2v);
  assign push_pair.v1   = e1v && e2v;
  assign push_pair.rec0 = e1v ? e1 : e2;
  assign push_pair.rec1 = e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      line     <= att_pkg::POS_ONE;
      col      <= att_pkg::POS_ONE;
      tok_line <= att_pkg::POS_ONE;
      tok_col  <= att_pkg::POS_ONE;
      cnt      <= '0;
      acc      <= '0;
      rmatch   <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      line     <= line_next;
      col      <= col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      cnt      <= cnt_next;
      acc      <= acc_next;
      rmatch   <= rmatch_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/att_back.sv
// Token queue and output sequencer: stores token pairs and sends them one beat at a time.
`default_nettype none

module att_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire att_pkg::tok_pair_t   push_pair,
  output logic                      q_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output att_pkg::tok_rec_t         out_rec,
  output logic                      out_last
);

  att_pkg::tok_pair_t               mem [att_pkg::QUEUE_DEPTH];
  logic [att_pkg::QPTR_BITS-1:0]    wr_ptr, rd_ptr;
  logic [att_pkg::QCNT_BITS-1:0]    count;
  logic                             sub;
  att_pkg::tok_pair_t               head;
  logic                             beat, pop;

  assign head      = mem[rd_ptr];
  assign q_ready   = count != att_pkg::QCNT_BITS'(att_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_rec   = sub ? head.rec1 : head.rec0;
  assign out_last  = sub || !head.v1;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && out_last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + att_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + att_pkg::QPTR_BITS'(1);
        sub    <= 1'b0;
      end else if (beat) begin
        // advance to the second token of this pair
        sub <= 1'b1;
      end
      if (push && !pop) begin
        count <= count + att_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - att_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire
